// File: hdl/ddv_pkg.sv
// Shared types, status codes and calendar helpers for the date validator.
`default_nettype none
package ddv_pkg;

   localparam int CHAR_W  = 8;
   localparam int VALUE_W = 27;
   localparam int COUNT_W = 4;
   localparam int DIGITS  = 8;

   localparam logic [COUNT_W-1:0] COUNT_SAT   = 4'd9;
   localparam logic [COUNT_W-1:0] COUNT_SHORT = 4'd6;
   localparam logic [COUNT_W-1:0] COUNT_LONG  = 4'd8;

   localparam logic [VALUE_W-1:0] YYMMDD_BASE = 27'd20000000;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

   localparam logic [1:0] STATUS_VALID      = 2'd0;
   localparam logic [1:0] STATUS_BAD_FORMAT = 2'd1;
   localparam logic [1:0] STATUS_BAD_DATE   = 2'd2;

   // One finished string, handed from the front end to the checker.
   typedef struct packed {
      logic [COUNT_W-1:0]        count;
      logic                      non_digit;
      logic [VALUE_W-1:0]        value;
      logic [DIGITS-1:0][3:0]    digits;   // digits[0] is the newest digit
   } job_type;

   // Days in a month given as 1..12; February grows to 29 in a leap year.
   function automatic logic [4:0] month_limit(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2:                         days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:      days = 5'd30;
         default:                      days = 5'd31;
      endcase
      return days;
   endfunction

   // A two-digit decimal number is a multiple of four when 2*tens + ones is.
   function automatic logic bcd_mod4_zero(input logic [3:0] tens, input logic [3:0] ones);
      logic [1:0] low;
      low = ones[1:0] + {tens[0], 1'b0};
      return low == 2'd0;
   endfunction

endpackage
`default_nettype wire

// File: hdl/ddv_front.sv
// Front end: takes characters, keeps the count, value and digit history of a string.
`default_nettype none
module ddv_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ddv_pkg::CHAR_W-1:0]  req_char_code,
   input  wire logic                        req_is_last,
   input  wire logic                        queue_full,
   output logic                             push,
   output ddv_pkg::job_type                 push_job
);

   logic [ddv_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [ddv_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic                             non_digit_ff, non_digit_in;
   logic [ddv_pkg::DIGITS-1:0][3:0]  digits_ff, digits_in;
   logic                             accept;
   logic                             is_digit;
   logic [3:0]                       digit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = (req_char_code >= ddv_pkg::CHAR_ZERO) &&
                      (req_char_code <= ddv_pkg::CHAR_NINE);
   assign digit     = req_char_code[3:0];

   always_comb begin
      count_in     = count_ff;
      value_in     = value_ff;
      non_digit_in = non_digit_ff;
      digits_in    = digits_ff;
      if (is_digit) begin
         // Digits after the eighth character are dropped so the value stays in range.
         if (count_ff < ddv_pkg::COUNT_LONG) begin
            value_in  = (value_ff << 3) + (value_ff << 1) +
                        {{(ddv_pkg::VALUE_W-4){1'b0}}, digit};
            digits_in = {digits_ff[ddv_pkg::DIGITS-2:0], digit};
         end
      end else begin
         non_digit_in = 1'b1;
      end
      if (count_ff < ddv_pkg::COUNT_SAT) begin
         count_in = count_ff + 4'd1;
      end
   end

   assign push               = accept && req_is_last;
   assign push_job.count     = count_in;
   assign push_job.non_digit = non_digit_in;
   assign push_job.value     = value_in;
   assign push_job.digits    = digits_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         value_ff     <= '0;
         non_digit_ff <= 1'b0;
         digits_ff    <= '0;
      end else if (accept) begin
         if (req_is_last) begin
            count_ff     <= '0;
            value_ff     <= '0;
            non_digit_ff <= 1'b0;
            digits_ff    <= '0;
         end else begin
            count_ff     <= count_in;
            value_ff     <= value_in;
            non_digit_ff <= non_digit_in;
            digits_ff    <= digits_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/ddv_queue.sv
// Two-entry queue of finished strings between the front end and the checker.
`default_nettype none
module ddv_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  ddv_pkg::job_type       push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output ddv_pkg::job_type       head_job
);

   ddv_pkg::job_type  entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full       = fill_ff == 2'd2;
   assign head_valid = fill_ff != 2'd0;
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("item pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("item popped from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> (fill_ff == $past(fill_ff) + 2'd1))
      else $error("queue fill count lost a push");
`endif

endmodule
`default_nettype wire

// File: hdl/ddv_back.sv
// Back end: checks format and calendar validity and holds the result register.
`default_nettype none
module ddv_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  ddv_pkg::job_type                  head_job,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [ddv_pkg::VALUE_W-1:0]       rsp_date_value
);

   logic                          valid_ff;
   logic [1:0]                    status_ff, status_in;
   logic [ddv_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic                          short_form;
   logic                          good_format;
   logic [3:0]                    m_hi, m_lo, d_hi, d_lo, y_hi, y_lo, c_hi, c_lo;
   logic                          month_ok;
   logic [3:0]                    month_bin;
   logic [6:0]                    day_bin;
   logic                          leap;
   logic [4:0]                    limit;
   logic                          day_ok;
   logic [ddv_pkg::VALUE_W-1:0]   full_value;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      short_form  = head_job.count == ddv_pkg::COUNT_SHORT;
      good_format = !head_job.non_digit &&
                    (short_form || head_job.count == ddv_pkg::COUNT_LONG);
      d_lo = head_job.digits[0];
      d_hi = head_job.digits[1];
      m_lo = head_job.digits[2];
      m_hi = head_job.digits[3];
      y_lo = head_job.digits[4];
      y_hi = head_job.digits[5];
      c_lo = head_job.digits[6];
      c_hi = head_job.digits[7];

      month_ok  = ((m_hi == 4'd0) && (m_lo != 4'd0)) ||
                  ((m_hi == 4'd1) && (m_lo <= 4'd2));
      month_bin = m_hi[0] ? (m_lo + 4'd10) : m_lo;

      // A century year is a leap year only when its century is a multiple of four.
      // The short form always means the century 20.
      if ((y_hi == 4'd0) && (y_lo == 4'd0)) begin
         leap = short_form ? 1'b1 : ddv_pkg::bcd_mod4_zero(c_hi, c_lo);
      end else begin
         leap = ddv_pkg::bcd_mod4_zero(y_hi, y_lo);
      end

      limit   = ddv_pkg::month_limit(month_bin, leap);
      day_bin = {d_hi, 3'b000} + {2'b00, d_hi, 1'b0} + {3'b000, d_lo};
      day_ok  = (day_bin != 7'd0) && (day_bin <= {2'b00, limit});

      full_value = head_job.value + (short_form ? ddv_pkg::YYMMDD_BASE : '0);

      if (!good_format) begin
         status_in = ddv_pkg::STATUS_BAD_FORMAT;
         value_in  = '0;
      end else if (!month_ok || !day_ok) begin
         status_in = ddv_pkg::STATUS_BAD_DATE;
         value_in  = '0;
      end else begin
         status_in = ddv_pkg::STATUS_VALID;
         value_in  = full_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_date_value = value_ff;

endmodule
`default_nettype wire

// File: hdl/digit_date_validator_core.sv
// Top level of the date string validator.
//
// The req_ channel carries one ASCII character per item, with req_is_last set on
// the final character of a string. The rsp_ channel returns one item per string:
// rsp_status (valid, bad format, not a calendar date) and rsp_date_value, the
// YYYYMMDD value when valid and zero otherwise. Six-digit strings are read as
// YYMMDD in the years 2000 to 2099.
//
// One character is taken every cycle while req_stall is low; the per-character work
// is a multiply by ten and add in the front end. When a final character is taken, its
// string enters a two-entry queue; the checker takes the queue head and registers the
// result; rsp_valid rises when the result register is loaded. Back-to-back strings,
// including one-character strings, run at one per cycle while rsp_stall is low.
//
// req_stall rises only while the queue is full, which happens when the receiver
// holds rsp_stall; the result register then keeps its item until it is taken.
// Synchronous reset empties the queue and result register and clears the
// partial string.
`default_nettype none
module digit_date_validator_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ddv_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic                         req_is_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [ddv_pkg::VALUE_W-1:0]       rsp_date_value
);

   logic              queue_full;
   logic              push;
   ddv_pkg::job_type  push_job;
   logic              pop;
   logic              head_valid;
   ddv_pkg::job_type  head_job;

   ddv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   ddv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ddv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_date_value (rsp_date_value)
   );

endmodule
`default_nettype wire
